@@ design/opbf_pkg.sv @@
// Shared types and constants for the odd parity bit framer.
package opbf_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned BITS_W  = 4;
    localparam int unsigned ACC_W   = 16;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned SUM_W   = 5;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [BITS_W-1:0] BITS_FULL  = 4'd8;
    localparam logic [BITS_W-1:0] BITS_SHORT = 4'd7;
    localparam logic [SUM_W-1:0]  GROUP_LEN  = 5'd9;
    localparam logic [SUM_W-1:0]  BYTE_LEN   = 5'd8;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // one result word
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [BITS_W-1:0] bits;
        logic              good;
    } t_result;

    // one queue entry: the one or two results caused by a single input word
    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_entry;

endpackage

@@ design/opbf_front.sv @@
// Front end: accepts input words, runs the bit accumulator and builds queue entries.
module opbf_front
    import opbf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_direction,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_byte_in,
    input  logic              i_last_in,
    input  logic [BITS_W-1:0] i_bits_in,
    output logic              o_q_push,
    output t_entry            o_q_entry
);

    logic             r_dir;
    logic [ACC_W-1:0] r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ok;
    logic             r_first;

    logic [ACC_W-1:0] n_acc;
    logic [CNT_W-1:0] n_cnt;
    logic             n_ok;
    logic             n_first;

    logic             short_frame;
    logic             parity;
    logic [ACC_W-1:0] enc_sum;
    logic [ACC_W-1:0] enc_acc1;
    logic [SUM_W-1:0] enc_c1;
    logic [BITS_W-1:0] dec_nb;
    logic [BYTE_W:0]  dec_mask;
    logic [BYTE_W-1:0] dec_valid;
    logic [ACC_W-1:0] dec_sum;
    logic [SUM_W-1:0] dec_c;
    logic             dec_grp;
    logic             dec_ok;
    t_entry           ent;
    logic             has_result;

    assign short_frame = r_first && i_last_in && (i_bits_in == BITS_SHORT);
    assign parity      = ~(^i_byte_in);

    // encode: 9-bit group appended above pending bits (pending count below 8)
    assign enc_sum  = r_acc | (ACC_W'({parity, i_byte_in}) << r_cnt);
    assign enc_acc1 = enc_sum >> BYTE_W;
    assign enc_c1   = SUM_W'(r_cnt) + SUM_W'(1);

    // decode: only the valid low bits of the byte are taken
    always_comb begin
        dec_nb = BITS_FULL;
        if (i_last_in) begin
            dec_nb = (i_bits_in > BITS_FULL) ? BITS_FULL : i_bits_in;
        end
    end
    assign dec_mask  = (BYTE_W+1)'(((BYTE_W+1)'(1) << dec_nb) - (BYTE_W+1)'(1));
    assign dec_valid = i_byte_in & dec_mask[BYTE_W-1:0];
    assign dec_sum   = r_acc | (ACC_W'(dec_valid) << r_cnt);
    assign dec_c     = SUM_W'(r_cnt) + SUM_W'(dec_nb);
    assign dec_grp   = (dec_c >= GROUP_LEN);
    assign dec_ok    = r_ok && !(dec_grp && (dec_sum[BYTE_W] != ~(^dec_sum[BYTE_W-1:0])));

    always_comb begin
        ent        = '0;
        has_result = 1'b0;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_ok       = r_ok;
        n_first    = 1'b0;
        if (short_frame) begin
            ent.r0     = '{data: i_byte_in, last: 1'b1, bits: BITS_SHORT,
                           good: (r_dir == DIR_DECODE)};
            has_result = 1'b1;
            n_first    = 1'b1;
        end else if (r_dir == DIR_ENCODE) begin
            has_result = 1'b1;
            ent.r0     = '{data: enc_sum[BYTE_W-1:0], last: 1'b0, bits: BITS_FULL,
                           good: 1'b0};
            if (enc_c1 >= BYTE_LEN) begin
                // second whole byte; nothing left over
                ent.two = 1'b1;
                ent.r1  = '{data: enc_acc1[BYTE_W-1:0], last: i_last_in, bits: BITS_FULL,
                            good: 1'b0};
                n_acc   = '0;
                n_cnt   = '0;
            end else begin
                n_acc = enc_acc1;
                n_cnt = CNT_W'(enc_c1);
                if (i_last_in) begin
                    ent.two = 1'b1;
                    ent.r1  = '{data: enc_acc1[BYTE_W-1:0], last: 1'b1,
                                bits: BITS_W'(enc_c1), good: 1'b0};
                end
            end
        end else begin
            n_ok  = dec_ok;
            n_acc = dec_sum;
            n_cnt = CNT_W'(dec_c);
            if (dec_grp) begin
                has_result = 1'b1;
                ent.r0 = '{data: dec_sum[BYTE_W-1:0], last: 1'b0, bits: BITS_FULL,
                           good: 1'b0};
                n_acc  = dec_sum >> (BYTE_W + 1);
                n_cnt  = CNT_W'(dec_c - GROUP_LEN);
                if (i_last_in) begin
                    ent.two = 1'b1;
                    ent.r1  = '{data: '0, last: 1'b1, bits: '0, good: dec_ok};
                end
            end else if (i_last_in) begin
                has_result = 1'b1;
                ent.r0 = '{data: '0, last: 1'b1, bits: '0, good: dec_ok};
            end
        end
        if (i_last_in) begin
            n_acc   = '0;
            n_cnt   = '0;
            n_ok    = 1'b1;
            n_first = 1'b1;
        end
    end

    assign o_q_push  = i_accept && has_result;
    assign o_q_entry = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= DIR_ENCODE;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_ok    <= 1'b1;
            r_first <= 1'b1;
        end else if (i_cfg_valid) begin
            r_dir   <= i_cfg_direction;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_ok    <= 1'b1;
            r_first <= 1'b1;
        end else if (i_accept) begin
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_ok    <= n_ok;
            r_first <= n_first;
        end
    end

endmodule

@@ design/opbf_queue.sv @@
// Two-entry queue between the front end and the output stage.
module opbf_queue
    import opbf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_entry o_head
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]    r_wp;
    logic [PTR_W-1:0]    r_rp;
    logic [CNT_QW-1:0]   r_count;

    assign o_full  = (r_count == CNT_QW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= PTR_W'(r_wp + PTR_W'(1));
            end
            if (i_pop) begin
                r_rp <= PTR_W'(r_rp + PTR_W'(1));
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= CNT_QW'(r_count + CNT_QW'(1));
                2'b01:   r_count <= CNT_QW'(r_count - CNT_QW'(1));
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_QW'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

@@ design/opbf_back.sv @@
// Output stage: plays out entry results, one word per cycle while popped.
module opbf_back
    import opbf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_entry  i_q_head,
    output logic    o_q_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    logic    r_valid;
    logic    r_sel;
    t_result r_res;
    logic    load;

    assign load    = !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop = load && (r_sel || !i_q_head.two);
    assign o_empty = !r_valid;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= r_sel ? i_q_head.r1 : i_q_head.r0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_sel   <= !r_sel && i_q_head.two;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_sel_holds_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel |-> (!i_q_empty && i_q_head.two && r_valid))
        else $error("second result pending without its entry");
`endif

endmodule

@@ design/odd_parity_bit_framer_unit.sv @@
// Top level of the odd parity bit framer: front end, entry queue and output stage.
// Odd parity framer for a contactless card link. With direction 0 each input byte is
// followed by its odd parity bit and the 9-bit groups are packed LSB first into output
// words; the last word of a frame carries its valid bit count. With direction 1 the
// packed stream is split into 9-bit groups, one data word per group, and the word
// marked last gets a status-only result (bits_out 0) with the overall parity verdict.
// A first word marked last with 7 bits passes through as is. Writing direction also
// drops any frame in progress; write it only while the block is idle. The output stage
// hands out one result word per cycle while the consumer keeps popping, so words with
// at most one result run at one per cycle, while a word with two results (an encode
// word that completes a second byte or flushes leftover bits at frame end, a decode
// word that completes a group at frame end) holds the output for both of them.
// A two-entry queue sits between front end and output register, so input and output
// stall independently. A word's first result goes into the queue on acceptance, then
// into the output register, from which it is popped.
module odd_parity_bit_framer_unit
    import opbf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_direction,
    // input queue side
    input  logic              i_push,
    output logic              o_full,
    input  logic [BYTE_W-1:0] i_byte_in,
    input  logic              i_last_in,
    input  logic [BITS_W-1:0] i_bits_in,
    // result queue side
    output logic              o_empty,
    input  logic              i_pop,
    output logic [BYTE_W-1:0] o_byte_out,
    output logic              o_last_out,
    output logic [BITS_W-1:0] o_bits_out,
    output logic              o_parity_good
);

    logic    accept;
    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    t_entry  q_in;
    t_entry  q_head;
    t_result res;

    // the user must write registers only while idle; the block does not enforce it, and the port never stalls
    assign o_cfg_ready = 1'b1;

    // front end stalls only when the queue has no room
    assign o_full = q_full;
    assign accept = i_push && !q_full;

    opbf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_direction (i_cfg_direction),
        .i_accept        (accept),
        .i_byte_in       (i_byte_in),
        .i_last_in       (i_last_in),
        .i_bits_in       (i_bits_in),
        .o_q_push        (q_push),
        .o_q_entry       (q_in)
    );

    opbf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    opbf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_result  (res)
    );

    assign o_byte_out    = res.data;
    assign o_last_out    = res.last;
    assign o_bits_out    = res.bits;
    assign o_parity_good = res.good;

endmodule
